// File: rtl/pxf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxf_pkg: shared types and constants of the parity-split XOR Fenwick tree
// Sizes of the element store and the two trees, and the memory request word.
// ----------------------------------------------------------------------------
package pxf_pkg;

    // Array size and derived tree sizes
    localparam int MAX_LEN    = 1024;
    localparam int ODD_NODES  = (MAX_LEN + 1) / 2;
    localparam int EVEN_NODES = MAX_LEN / 2;

    // Field widths
    localparam int POS_W  = 11;
    localparam int DATA_W = 64;
    localparam int NODE_W = POS_W;
    localparam int TR_AW  = $clog2(ODD_NODES + 1);

    // Stream packing
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 64;

    // Item kinds carried on the input tuser
    localparam logic OP_ASSIGN = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // One access to the stores per cycle
    typedef struct packed {
        logic              el_we;
        logic [POS_W-1:0]  el_addr;
        logic [DATA_W-1:0] el_wdata;
        logic              tr_we;
        logic              tr_odd;
        logic              tr_clr;
        logic [TR_AW-1:0]  tr_addr;
        logic [DATA_W-1:0] tr_wdata;
    } t_mem_req;

endpackage

// File: rtl/pxf_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxf_mem: element store and the odd and even XOR trees
// One address per store per cycle; read data is registered, write goes to the
// same address. A clear request writes both trees at once.
// ----------------------------------------------------------------------------
module pxf_mem
    import pxf_pkg::*;
(
    input  logic              i_clk,
    input  t_mem_req          i_req,
    output logic [DATA_W-1:0] o_el_rd,
    output logic [DATA_W-1:0] o_tr_rd
);

    logic [DATA_W-1:0] r_el   [0:MAX_LEN];
    logic [DATA_W-1:0] r_odd  [0:ODD_NODES];
    logic [DATA_W-1:0] r_even [0:EVEN_NODES];
    logic [DATA_W-1:0] r_el_rd;
    logic [DATA_W-1:0] r_odd_rd;
    logic [DATA_W-1:0] r_even_rd;
    logic              r_sel_odd;

    // Element store
    always_ff @(posedge i_clk) begin
        if (i_req.el_we) begin
            r_el[i_req.el_addr] <= i_req.el_wdata;
        end
        r_el_rd <= r_el[i_req.el_addr];
    end

    // Odd tree
    always_ff @(posedge i_clk) begin
        if (i_req.tr_we && (i_req.tr_odd || i_req.tr_clr)) begin
            r_odd[i_req.tr_addr] <= i_req.tr_wdata;
        end
        r_odd_rd <= r_odd[i_req.tr_addr];
    end

    // Even tree
    always_ff @(posedge i_clk) begin
        if (i_req.tr_we && (!i_req.tr_odd || i_req.tr_clr)) begin
            r_even[i_req.tr_addr] <= i_req.tr_wdata;
        end
        r_even_rd <= r_even[i_req.tr_addr];
        r_sel_odd <= i_req.tr_odd;
    end

    assign o_el_rd = r_el_rd;
    assign o_tr_rd = r_sel_odd ? r_odd_rd : r_even_rd;

endmodule

// File: rtl/parity_split_xor_fenwick_tree_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parity_split_xor_fenwick_tree_core: XOR Fenwick trees split by index parity
// Assign words at positions and query odd-length spans by two prefix XORs.
// Steps: assign reads the old word, stores the new one, then reads and writes
//   each tree node; query reads and folds each node of both prefix walks;
//   errors and even spans go straight to the result. Input tready stays low
//   until the result enters the output register; tree nodes are updated by
//   read-modify-write through the single tree memory port.
// Reset: synchronous; then a clearing pass zeroes every store; tready is low.
// ----------------------------------------------------------------------------
module parity_split_xor_fenwick_tree_core
    import pxf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // position, new_value, left, right (lowest bit up), zero padded
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // op
    input  logic                 i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // answer
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // error
    output logic                 o_m_tuser
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_ELRD, S_ELUPD, S_URD, S_UWR, S_QRD, S_QACC, S_DONE
    } t_state;

    t_state            r_state,  n_state;
    logic [POS_W-1:0]  r_clr,    n_clr;
    logic [POS_W-1:0]  r_pos,    n_pos;
    logic [DATA_W-1:0] r_val,    n_val;
    logic [NODE_W-1:0] r_node,   n_node;
    logic [NODE_W-1:0] r_node2,  n_node2;
    logic              r_odd,    n_odd;
    logic              r_phase,  n_phase;
    logic [DATA_W-1:0] r_acc,    n_acc;
    logic              r_err,    n_err;
    logic              r_mvalid, n_mvalid;
    logic [DATA_W-1:0] r_mdata,  n_mdata;
    logic              r_muser,  n_muser;

    t_mem_req          w_req;
    logic [DATA_W-1:0] w_el_rd;
    logic [DATA_W-1:0] w_tr_rd;

    logic [POS_W-1:0]  w_pos, w_lo, w_hi;
    logic [NODE_W-1:0] w_bound, w_lowbit;
    logic              w_pos_bad, w_q_bad;

    assign w_pos = i_s_tdata[10:0];
    assign w_lo  = i_s_tdata[85:75];
    assign w_hi  = i_s_tdata[96:86];

    assign w_pos_bad = (w_pos == '0) || (w_pos > POS_W'(MAX_LEN));
    assign w_q_bad   = (w_lo == '0) || (w_hi == '0) || (w_lo > POS_W'(MAX_LEN)) ||
                       (w_hi > POS_W'(MAX_LEN)) || (w_lo > w_hi);

    assign w_bound  = r_odd ? NODE_W'(ODD_NODES) : NODE_W'(EVEN_NODES);
    assign w_lowbit = r_node & (~r_node + NODE_W'(1));

    pxf_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_el_rd (w_el_rd),
        .o_tr_rd (w_tr_rd)
    );

    // Sequencer: next state, store accesses and walk registers
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_pos    = r_pos;
        n_val    = r_val;
        n_node   = r_node;
        n_node2  = r_node2;
        n_odd    = r_odd;
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_err    = r_err;
        n_mvalid = r_mvalid;
        n_mdata  = r_mdata;
        n_muser  = r_muser;

        w_req          = '0;
        w_req.el_addr  = r_pos;
        w_req.el_wdata = r_val;
        w_req.tr_odd   = r_odd;
        w_req.tr_addr  = r_node[TR_AW-1:0];
        w_req.tr_wdata = w_tr_rd ^ r_acc;

        // Drop the output word once taken
        if (r_mvalid && i_m_tready) begin
            n_mvalid = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                w_req.el_we    = 1'b1;
                w_req.el_addr  = r_clr;
                w_req.el_wdata = '0;
                w_req.tr_clr   = 1'b1;
                w_req.tr_we    = (r_clr <= POS_W'(ODD_NODES));
                w_req.tr_addr  = r_clr[TR_AW-1:0];
                w_req.tr_wdata = '0;
                n_clr          = r_clr + POS_W'(1);
                if (r_clr == POS_W'(MAX_LEN)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_acc = '0;
                    n_err = 1'b0;
                    if (i_s_tuser == OP_ASSIGN) begin
                        n_pos = w_pos;
                        n_val = i_s_tdata[74:11];
                        n_odd = w_pos[0];
                        n_node = w_pos[0] ? ({1'b0, w_pos[POS_W-1:1]} + NODE_W'(1))
                                          : {1'b0, w_pos[POS_W-1:1]};
                        if (w_pos_bad) begin
                            n_err   = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_ELRD;
                        end
                    end else begin
                        n_odd   = w_lo[0];
                        n_phase = 1'b0;
                        if (w_lo[0]) begin
                            n_node  = {1'b0, w_hi[POS_W-1:1]} + NODE_W'(1);
                            n_node2 = {1'b0, w_lo[POS_W-1:1]};
                        end else begin
                            n_node  = {1'b0, w_hi[POS_W-1:1]};
                            n_node2 = {1'b0, w_lo[POS_W-1:1]} - NODE_W'(1);
                        end
                        if (w_q_bad) begin
                            n_err   = 1'b1;
                            n_state = S_DONE;
                        end else if (w_lo[0] != w_hi[0]) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_QRD;
                        end
                    end
                end
            end
            // Read the old word; its data arrives next cycle
            S_ELRD: begin
                n_state = S_ELUPD;
            end
            // Store the new word and keep old ^ new as the tree delta
            S_ELUPD: begin
                w_req.el_we = 1'b1;
                n_acc       = w_el_rd ^ r_val;
                n_state     = S_URD;
            end
            // Read a tree node, or stop past the last node
            S_URD: begin
                if ((r_node == '0) || (r_node > w_bound)) begin
                    n_acc   = '0;
                    n_state = S_DONE;
                end else begin
                    n_state = S_UWR;
                end
            end
            // Fold the delta into the node and climb to its parent range
            S_UWR: begin
                w_req.tr_we = 1'b1;
                n_node      = r_node + w_lowbit;
                n_state     = S_URD;
            end
            // Read a prefix node; switch to the second prefix at node zero
            S_QRD: begin
                if (r_node == '0) begin
                    if (!r_phase) begin
                        n_phase = 1'b1;
                        n_node  = r_node2;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_QACC;
                end
            end
            S_QACC: begin
                n_acc   = r_acc ^ w_tr_rd;
                n_node  = r_node - w_lowbit;
                n_state = S_QRD;
            end
            // Hand the result to the output register when it is free
            S_DONE: begin
                if (!r_mvalid || i_m_tready) begin
                    n_mvalid = 1'b1;
                    n_mdata  = r_acc;
                    n_muser  = r_err;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_mvalid <= n_mvalid;
        end
        r_pos   <= n_pos;
        r_val   <= n_val;
        r_node  <= n_node;
        r_node2 <= n_node2;
        r_odd   <= n_odd;
        r_phase <= n_phase;
        r_acc   <= n_acc;
        r_err   <= n_err;
        r_mdata <= n_mdata;
        r_muser <= n_muser;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_mvalid;
    assign o_m_tdata  = r_mdata;
    assign o_m_tuser  = r_muser;

endmodule
